[rtl/core/qrs_peak_detector_macros.svh]
// Assertion macros shared by the QRS peak detector RTL
`ifndef QRS_PEAK_DETECTOR_MACROS_SVH
`define QRS_PEAK_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define QPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrs_peak_detector: assertion failed");

// Next-cycle implication, sampled on i_clk, disabled while i_rst_n is low
`define QPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrs_peak_detector: assertion failed");

`endif

[rtl/core/qrs_pd_pkg.sv]
// Shared types and constants of the QRS peak detector
package qrs_pd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WINDOW_DEFAULT = 30;
    localparam int HIST_TAPS      = 4;
    // Output queue depth, power of two
    localparam int OUT_FIFO_DEPTH = 8;

    localparam logic signed [SAMPLE_W-1:0] THR_RESET = 16'sd200;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic    qrs_detected;
        t_sample integrated_value;
    } t_result;

endpackage

[rtl/core/qrs_pd_if.sv]
// Channel interfaces of the QRS peak detector: samples, results, threshold writes
interface qrs_pd_in_if;
    logic                 valid;
    logic                 ready;
    qrs_pd_pkg::t_sample  sample;
    logic                 block_start;

    modport source (output valid, output sample, output block_start, input ready);
    modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface qrs_pd_out_if;
    logic                 valid;
    logic                 ready;
    logic                 qrs_detected;
    qrs_pd_pkg::t_sample  integrated_value;

    modport source (output valid, output qrs_detected, output integrated_value, input ready);
    modport sink   (input valid, input qrs_detected, input integrated_value, output ready);
endinterface

interface qrs_pd_cfg_if;
    logic                 valid;
    logic                 ready;
    qrs_pd_pkg::t_sample  initial_threshold;

    modport source (output valid, output initial_threshold, input ready);
    modport sink   (input valid, input initial_threshold, output ready);
endinterface

[rtl/core/qrs_peak_detector.sv]
// QRS peak detector top level: derivative, square, window average, adaptive threshold.
// A sample's result is presented after the r1, r2, r3, r4 registers and the result queue.
// Throughput: one sample per cycle while the queue has room, paced by the one write and
// one read per cycle of the square-window ring; an 8-entry queue absorbs output stalls.
// Reset (synchronous, active low) clears index, ring pointer, sum and peak, loads the
// threshold with 200; the ring and history hold no reset and need no clearing pass.
`include "qrs_peak_detector_macros.svh"

module qrs_peak_detector #(
    parameter int WINDOW = qrs_pd_pkg::WINDOW_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qrs_pd_in_if.sink             i_in,
    qrs_pd_cfg_if.sink            i_cfg,
    qrs_pd_out_if.source          o_out
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int SW        = qrs_pd_pkg::SAMPLE_W;
    localparam int IDX_LIMIT = (WINDOW > qrs_pd_pkg::HIST_TAPS) ? WINDOW
                                                                : qrs_pd_pkg::HIST_TAPS;
    localparam int IW        = $clog2(IDX_LIMIT + 1);
    localparam int AW        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // Window sum: WINDOW signed 16-bit terms
    localparam int SUMW      = SW + $clog2(WINDOW);
    // Reciprocal for an exact floor(mag / WINDOW), mag < 2**SUMW
    localparam int RSHIFT    = SUMW + $clog2(WINDOW);
    localparam int MW        = SUMW + 2;
    localparam logic [63:0] RECIP64 = ((64'd1 << RSHIFT) + 64'(WINDOW) - 64'd1)
                                      / 64'(WINDOW);
    localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
    // product wide enough to hold the quotient field above the shift
    localparam int PW        = RSHIFT + SUMW;
    localparam int DW        = SW + 3;
    localparam int FD        = qrs_pd_pkg::OUT_FIFO_DEPTH;
    localparam int FAW       = $clog2(FD);
    localparam int FCW       = FAW + 1;

    // ------------------------------------------------------------------
    // Configuration: threshold loaded at each block start
    // ------------------------------------------------------------------
    qrs_pd_pkg::t_sample r_init_thr;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr <= qrs_pd_pkg::THR_RESET;
        end else if (i_cfg.valid) begin
            r_init_thr <= i_cfg.initial_threshold;
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every accepted sample holds a queue slot until popped
    // ------------------------------------------------------------------
    logic [FCW-1:0] r_pend;
    logic           s_acc;
    logic           s_pop;

    assign i_in.ready = (r_pend < FCW'(FD));
    assign s_acc      = i_in.valid & i_in.ready;
    assign s_pop      = o_out.valid & o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({s_acc, s_pop})
                2'b10:   r_pend <= r_pend + FCW'(1);
                2'b01:   r_pend <= r_pend - FCW'(1);
                default: r_pend <= r_pend;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: block bookkeeping, derivative, ring read
    // ------------------------------------------------------------------
    qrs_pd_pkg::t_sample r_hist [qrs_pd_pkg::HIST_TAPS];
    logic [IW-1:0]       r_idx;
    logic [AW-1:0]       r_ring;

    logic [IW-1:0]         s0_idx;
    logic [AW-1:0]         s0_ring;
    logic                  s0_hist_ok;
    logic                  s0_full;
    logic signed [DW-1:0]  s0_t;
    logic signed [DW-1:0]  s0_tadj;
    qrs_pd_pkg::t_sample   s0_deriv;
    logic [IW-1:0]         n_idx;
    logic [AW-1:0]         n_ring;

    always_comb begin
        s0_idx     = i_in.block_start ? '0 : r_idx;
        s0_ring    = i_in.block_start ? '0 : r_ring;
        s0_hist_ok = (s0_idx >= IW'(qrs_pd_pkg::HIST_TAPS));
        s0_full    = (s0_idx >= IW'(WINDOW));
        // 2x[n] + x[n-1] - x[n-3] - 2x[n-4]
        s0_t       = (DW'(i_in.sample) <<< 1) + DW'(r_hist[0]) - DW'(r_hist[2])
                     - (DW'(r_hist[3]) <<< 1);
        // divide by 8 toward zero: bias negatives before the shift
        s0_tadj    = s0_t + (s0_t[DW-1] ? DW'(7) : DW'(0));
        s0_deriv   = s0_hist_ok ? s0_tadj[DW-1:3] : '0;
        n_idx      = (s0_idx < IW'(IDX_LIMIT)) ? s0_idx + IW'(1) : s0_idx;
        n_ring     = (s0_ring == AW'(WINDOW - 1)) ? '0 : s0_ring + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ring <= '0;
        end else if (s_acc) begin
            r_idx  <= n_idx;
            r_ring <= n_ring;
        end
    end

    // history taps: shift on every accepted sample, kept across blocks
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_hist[3] <= r_hist[2];
            r_hist[2] <= r_hist[1];
            r_hist[1] <= r_hist[0];
            r_hist[0] <= i_in.sample;
        end
    end

    // ------------------------------------------------------------------
    // Square-window ring memory: one read, one write per cycle
    // ------------------------------------------------------------------
    qrs_pd_pkg::t_sample r_ring_mem [WINDOW];
    qrs_pd_pkg::t_sample r_rd;

    logic                r2_valid;
    logic [AW-1:0]       r2_addr;
    qrs_pd_pkg::t_sample r2_sq;

    always_ff @(posedge i_clk) begin
        r_rd <= r_ring_mem[s0_ring];
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid) begin
            r_ring_mem[r2_addr] <= r2_sq;
        end
    end

    // Stage 0 -> 1 registers
    logic                r1_valid;
    logic                r1_start;
    logic                r1_full;
    logic [AW-1:0]       r1_addr;
    qrs_pd_pkg::t_sample r1_deriv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= s_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_start <= i_in.block_start;
        r1_full  <= s0_full;
        r1_addr  <= s0_ring;
        r1_deriv <= s0_deriv;
    end

    // ------------------------------------------------------------------
    // Stage 1: square, resolve the outgoing window entry
    // ------------------------------------------------------------------
    logic                rw_valid;
    logic [AW-1:0]       rw_addr;
    qrs_pd_pkg::t_sample rw_sq;

    logic signed [2*SW-1:0] s1_prod;
    qrs_pd_pkg::t_sample    s1_sq;
    qrs_pd_pkg::t_sample    s1_old;

    always_comb begin
        s1_prod = r1_deriv * r1_deriv;
        // keep the low half of the square as a signed value
        s1_sq   = s1_prod[SW-1:0];
        // forward writes that the registered read missed, newest first
        if (r2_valid && (r2_addr == r1_addr)) begin
            s1_old = r2_sq;
        end else if (rw_valid && (rw_addr == r1_addr)) begin
            s1_old = rw_sq;
        end else begin
            s1_old = r_rd;
        end
    end

    logic                r2_start;
    logic                r2_full;
    qrs_pd_pkg::t_sample r2_old;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            rw_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
            rw_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_start <= r1_start;
        r2_full  <= r1_full;
        r2_addr  <= r1_addr;
        r2_sq    <= s1_sq;
        r2_old   <= s1_old;
        // copy of the write taking place this edge
        rw_addr  <= r2_addr;
        rw_sq    <= r2_sq;
    end

    // ------------------------------------------------------------------
    // Stage 2: running window sum
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] r_sum;
    logic signed [SUMW-1:0] s2_base;
    logic signed [SUMW-1:0] s2_sq_ext;
    logic signed [SUMW-1:0] s2_old_ext;
    logic signed [SUMW-1:0] n_sum;

    always_comb begin
        s2_base    = r2_start ? '0 : r_sum;
        s2_sq_ext  = SUMW'(r2_sq);
        s2_old_ext = r2_full ? SUMW'(r2_old) : '0;
        n_sum      = s2_base + s2_sq_ext - s2_old_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r2_valid) begin
            r_sum <= n_sum;
        end
    end

    logic r3_valid;
    logic r3_start;
    logic r3_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_start <= r2_start;
        r3_full  <= r2_full;
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitude times reciprocal of WINDOW
    // ------------------------------------------------------------------
    logic [SUMW-1:0] s3_mag;
    logic [PW-1:0]   s3_prod;

    always_comb begin
        s3_mag  = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
        s3_prod = PW'(s3_mag) * PW'(RECIP);
    end

    logic            r4_valid;
    logic            r4_start;
    logic            r4_full;
    logic            r4_neg;
    logic [SUMW-1:0] r4_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_start <= r3_start;
        r4_full  <= r3_full;
        r4_neg   <= r_sum[SUMW-1];
        r4_q     <= s3_prod[RSHIFT +: SUMW];
    end

    // ------------------------------------------------------------------
    // Stage 4: sign, adaptive threshold, peak tracking
    // ------------------------------------------------------------------
    qrs_pd_pkg::t_sample r_peak;
    qrs_pd_pkg::t_sample r_thr;

    logic [SUMW-1:0]        s4_qs;
    qrs_pd_pkg::t_sample    s4_integ;
    qrs_pd_pkg::t_sample    s4_peak;
    qrs_pd_pkg::t_sample    s4_thr;
    qrs_pd_pkg::t_sample    n_peak;
    logic                   s4_det;
    logic signed [SW:0]     s4_mid;
    logic signed [SW:0]     s4_mid_adj;
    qrs_pd_pkg::t_sample    n_thr;

    always_comb begin
        s4_qs      = r4_neg ? (~r4_q + SUMW'(1)) : r4_q;
        s4_integ   = r4_full ? s4_qs[SW-1:0] : '0;
        s4_peak    = r4_start ? '0 : r_peak;
        s4_thr     = r4_start ? r_init_thr : r_thr;
        n_peak     = (s4_integ > s4_peak) ? s4_integ : s4_peak;
        s4_det     = (s4_integ > s4_thr);
        // halfway toward the peak, rounded toward zero
        s4_mid     = (SW+1)'(n_peak) + (SW+1)'(s4_thr);
        s4_mid_adj = s4_mid + (s4_mid[SW] ? (SW+1)'(1) : (SW+1)'(0));
        n_thr      = s4_det ? s4_mid_adj[SW:1] : s4_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
            r_thr  <= qrs_pd_pkg::THR_RESET;
        end else if (r4_valid) begin
            r_peak <= n_peak;
            r_thr  <= n_thr;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: decouples the pipeline from output stalls
    // ------------------------------------------------------------------
    qrs_pd_pkg::t_result r_fifo [FD];
    logic [FAW-1:0]      r_wptr;
    logic [FAW-1:0]      r_rptr;
    logic [FCW-1:0]      r_fcnt;

    always_ff @(posedge i_clk) begin
        if (r4_valid) begin
            r_fifo[r_wptr] <= '{qrs_detected: s4_det, integrated_value: s4_integ};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
        end else begin
            if (r4_valid) begin
                r_wptr <= r_wptr + FAW'(1);
            end
            if (s_pop) begin
                r_rptr <= r_rptr + FAW'(1);
            end
            case ({r4_valid, s_pop})
                2'b10:   r_fcnt <= r_fcnt + FCW'(1);
                2'b01:   r_fcnt <= r_fcnt - FCW'(1);
                default: r_fcnt <= r_fcnt;
            endcase
        end
    end

    assign o_out.valid            = (r_fcnt != '0);
    assign o_out.qrs_detected     = r_fifo[r_rptr].qrs_detected;
    assign o_out.integrated_value = r_fifo[r_rptr].integrated_value;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // queued results never outnumber outstanding transactions
    `QPD_ASSERT_IMP(a_fifo_within_pend, 1'b1, r_fcnt <= r_pend)
    // a finished result always finds a free queue slot
    `QPD_ASSERT_IMP(a_no_fifo_overflow, r4_valid, (r_fcnt != FCW'(FD)) || s_pop)
    // a block start restarts the window sum with this sample's square alone
    `QPD_ASSERT_NXT(a_sum_restart, r2_valid && r2_start, r_sum == $past(s2_sq_ext))
    // block index saturates at its limit
    `QPD_ASSERT_IMP(a_idx_saturates, 1'b1, r_idx <= IW'(IDX_LIMIT))

endmodule
